// ===== design/vec3_fixed_point_alu_top_macros.svh =====
// Assertion macros used by the vector ALU top module.
`ifndef VEC3_FIXED_POINT_ALU_TOP_MACROS_SVH
`define VEC3_FIXED_POINT_ALU_TOP_MACROS_SVH
`ifndef SYNTH
`define V3ALU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("vec3 alu assertion failed");
`define V3ALU_NEVER(lbl, clk, rstn, expr) \
    `V3ALU_ASSERT(lbl, clk, rstn, !(expr))
`else
`define V3ALU_ASSERT(lbl, clk, rstn, prop)
`define V3ALU_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== design/v3alu_pkg.sv =====
// Types, opcodes and the saturation helper of the vector ALU.
`default_nettype none
package v3alu_pkg;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_NEG   = 4'd2;
    localparam logic [3:0] OP_SCALE = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_MUL   = 4'd5;
    localparam logic [3:0] OP_DOT   = 4'd6;
    localparam logic [3:0] OP_CROSS = 4'd7;
    localparam logic [3:0] OP_LEN   = 4'd8;
    localparam logic [3:0] OP_NORM  = 4'd9;
    localparam logic [3:0] OP_CMP   = 4'd10;
    localparam logic [3:0] OP_EQ    = 4'd11;

    // Number of result bits of the square root, one per stage.
    localparam int ISQ_STAGES = 32;

    typedef logic [2:0][31:0] t_vec;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_sat;

    typedef struct packed {
        t_vec        vec;
        logic [31:0] sc;
        logic        lt;
        logic        gt;
        logic        eq;
        logic        sat;
    } t_early;

    typedef struct packed {
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        t_sat               res;
    } t_lane;

    // Clamp a wide signed value to the 32-bit range.
    function automatic t_sat sat32(input logic signed [65:0] v);
        t_sat r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v > 66'sd2147483647) begin
            r.sat = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            r.sat = 1'b1;
            r.val = 32'h8000_0000;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/v3alu_lane.sv =====
// One component lane: two multipliers, add/sub/neg and the per-lane rounding.
`default_nettype none
module v3alu_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic [3:0]         i_op,
    input  wire logic signed [31:0] i_a_i,
    input  wire logic signed [31:0] i_b_i,
    input  wire logic signed [31:0] i_a_j,
    input  wire logic signed [31:0] i_b_j,
    input  wire logic signed [31:0] i_a_k,
    input  wire logic signed [31:0] i_b_k,
    input  wire logic signed [31:0] i_s,
    input  wire logic [3:0]         i_op_s1,
    output v3alu_pkg::t_lane        o_lane
);

    logic signed [31:0] m1a, m1b, m2a, m2b;
    logic signed [63:0] n_p1, n_p2, r_p1, r_p2;
    logic signed [65:0] ax, bx, simple, e1, diff;
    v3alu_pkg::t_sat    n_simple, r_simple, res;

    always_comb begin
        m1a = i_a_i;
        m1b = i_b_i;
        m2a = '0;
        m2b = '0;
        unique case (i_op)
            v3alu_pkg::OP_SCALE: m1b = i_s;
            v3alu_pkg::OP_CROSS: begin
                m1a = i_a_j;
                m1b = i_b_k;
                m2a = i_a_k;
                m2b = i_b_j;
            end
            v3alu_pkg::OP_LEN, v3alu_pkg::OP_NORM: m1b = i_a_i;
            v3alu_pkg::OP_CMP: begin
                m1b = i_a_i;
                m2a = i_b_i;
                m2b = i_b_i;
            end
            default: ;
        endcase
        n_p1 = m1a * m1b;
        n_p2 = m2a * m2b;

        ax = {{34{i_a_i[31]}}, i_a_i};
        bx = {{34{i_b_i[31]}}, i_b_i};
        unique case (i_op)
            v3alu_pkg::OP_ADD: simple = ax + bx;
            v3alu_pkg::OP_SUB: simple = ax - bx;
            v3alu_pkg::OP_NEG: simple = -ax;
            default:           simple = '0;
        endcase
        n_simple = v3alu_pkg::sat32(simple);
    end

    always_ff @(posedge i_clk) begin
        r_p1     <= n_p1;
        r_p2     <= n_p2;
        r_simple <= n_simple;
    end

    // Products are rounded toward minus infinity; for cross the difference is formed first.
    always_comb begin
        e1   = {{2{r_p1[63]}}, r_p1};
        diff = e1 - {{2{r_p2[63]}}, r_p2};
        unique case (i_op_s1)
            v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB, v3alu_pkg::OP_NEG: res = r_simple;
            v3alu_pkg::OP_SCALE, v3alu_pkg::OP_MUL: res = v3alu_pkg::sat32(e1 >>> FRAC_BITS);
            v3alu_pkg::OP_CROSS: res = v3alu_pkg::sat32(diff >>> FRAC_BITS);
            default: res = '0;
        endcase
        o_lane.p1  = r_p1;
        o_lane.p2  = r_p2;
        o_lane.res = res;
    end

endmodule
`default_nettype wire

// ===== design/v3alu_merge.sv =====
// Merging stage: sums across lanes, dot, compare, equality and result select.
`default_nettype none
module v3alu_merge #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic [3:0]             i_op,
    input  wire v3alu_pkg::t_vec        i_a,
    input  wire v3alu_pkg::t_vec        i_b,
    input  wire v3alu_pkg::t_lane [2:0] i_lane,
    output v3alu_pkg::t_early           o_early,
    output logic [63:0]                 o_sumsq
);

    logic signed [65:0] sum1, sum2;
    v3alu_pkg::t_sat    dot;
    v3alu_pkg::t_early  n_early, r_early;
    logic [63:0]        r_sumsq;

    always_comb begin
        sum1 = {{2{i_lane[0].p1[63]}}, i_lane[0].p1}
             + {{2{i_lane[1].p1[63]}}, i_lane[1].p1}
             + {{2{i_lane[2].p1[63]}}, i_lane[2].p1};
        sum2 = {{2{i_lane[0].p2[63]}}, i_lane[0].p2}
             + {{2{i_lane[1].p2[63]}}, i_lane[1].p2}
             + {{2{i_lane[2].p2[63]}}, i_lane[2].p2};
        dot = v3alu_pkg::sat32(sum1 >>> FRAC_BITS);

        n_early = '0;
        unique case (i_op)
            v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB, v3alu_pkg::OP_NEG,
            v3alu_pkg::OP_SCALE, v3alu_pkg::OP_MUL, v3alu_pkg::OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    n_early.vec[i] = i_lane[i].res.val;
                end
                n_early.sat = i_lane[0].res.sat | i_lane[1].res.sat | i_lane[2].res.sat;
            end
            v3alu_pkg::OP_DOT: begin
                n_early.sc  = dot.val;
                n_early.sat = dot.sat;
            end
            v3alu_pkg::OP_CMP: begin
                n_early.lt = sum1 < sum2;
                n_early.gt = sum1 > sum2;
            end
            v3alu_pkg::OP_EQ: n_early.eq = (i_a == i_b);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_early <= n_early;
        r_sumsq <= sum1[63:0];
    end

    assign o_early = r_early;
    assign o_sumsq = r_sumsq;

endmodule
`default_nettype wire

// ===== design/v3alu_isqrt.sv =====
// Pipelined integer square root of a 64-bit value, one result bit per stage.
`default_nettype none
module v3alu_isqrt (
    input  wire logic        i_clk,
    input  wire logic [63:0] i_n,
    output logic [31:0]      o_root
);

    localparam int ST = v3alu_pkg::ISQ_STAGES;

    logic [63:0] r_n    [ST];
    logic [34:0] r_rem  [ST];
    logic [31:0] r_root [ST];
    logic [63:0] n_n    [ST];
    logic [34:0] n_rem  [ST];
    logic [31:0] n_root [ST];

    always_comb begin
        logic [63:0] nin;
        logic [34:0] rin, rsh, tst;
        logic [31:0] qin;
        logic        ge;
        for (int k = 0; k < ST; k++) begin
            if (k == 0) begin
                nin = i_n;
                rin = '0;
                qin = '0;
            end else begin
                nin = r_n[k-1];
                rin = r_rem[k-1];
                qin = r_root[k-1];
            end
            rsh       = {rin[32:0], nin[63:62]};
            tst       = {1'b0, qin, 2'b01};
            ge        = (rsh >= tst);
            n_n[k]    = {nin[61:0], 2'b00};
            n_rem[k]  = ge ? (rsh - tst) : rsh;
            n_root[k] = {qin[30:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ST; k++) begin
            r_n[k]    <= n_n[k];
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
        end
    end

    assign o_root = r_root[ST-1];

endmodule
`default_nettype wire

// ===== design/v3alu_div.sv =====
// Pipelined restoring divider of unsigned magnitudes, one quotient bit per stage.
`default_nettype none
module v3alu_div #(
    parameter int NW = 48
) (
    input  wire logic          i_clk,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [31:0]   i_den,
    output logic [NW-1:0]      o_quo,
    output logic [31:0]        o_den
);

    logic [NW-1:0] r_nq  [NW];
    logic [31:0]   r_rem [NW];
    logic [31:0]   r_den [NW];
    logic [NW-1:0] n_nq  [NW];
    logic [31:0]   n_rem [NW];
    logic [31:0]   n_den [NW];

    always_comb begin
        logic [NW-1:0] nin;
        logic [31:0]   rin, din;
        logic [32:0]   rsh, dif;
        logic          ge;
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                nin = i_num;
                rin = '0;
                din = i_den;
            end else begin
                nin = r_nq[k-1];
                rin = r_rem[k-1];
                din = r_den[k-1];
            end
            rsh      = {rin, nin[NW-1]};
            ge       = (rsh >= {1'b0, din});
            dif      = rsh - {1'b0, din};
            n_rem[k] = ge ? dif[31:0] : rsh[31:0];
            n_nq[k]  = {nin[NW-2:0], ge};
            n_den[k] = din;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NW; k++) begin
            r_nq[k]  <= n_nq[k];
            r_rem[k] <= n_rem[k];
            r_den[k] <= n_den[k];
        end
    end

    assign o_quo = r_nq[NW-1];
    assign o_den = r_den[NW-1];

endmodule
`default_nettype wire

// ===== design/vec3_fixed_point_alu_top.sv =====
// Top level of the three-component fixed-point vector ALU.
// The block takes one item (opcode, vectors A and B, a scalar) on every clock at which start
// is high; busy stays low, so a new item may follow in each cycle. Every item gives exactly
// one result (Q15.16 at the default FRAC_BITS), shown for one cycle with o_valid high; the
// receiver cannot stall it, so it must take the result in that cycle. Results leave in the
// order the items came in. Every operation passes through the 32-stage square root followed
// by the 32 + FRAC_BITS stage divider, so that all results keep the same delay; the
// sustained rate is one item per clock. Three lanes, one per component, each hold two
// multipliers, a merging stage forms sums, the dot product and the length compare, and
// three dividers, one per component, follow the square root. Divide by zero and
// normalize of a zero vector give a zero vector with o_divide_by_zero set; results out of
// the 32-bit range are clamped with o_saturated set. Unused opcodes give all fields zero.
`default_nettype none
`include "vec3_fixed_point_alu_top_macros.svh"
module vec3_fixed_point_alu_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [31:0] i_a_x,
    input  wire logic [31:0] i_a_y,
    input  wire logic [31:0] i_a_z,
    input  wire logic [31:0] i_b_x,
    input  wire logic [31:0] i_b_y,
    input  wire logic [31:0] i_b_z,
    input  wire logic [31:0] i_scalar_in,
    output logic             o_valid,
    output logic [31:0]      o_r_x,
    output logic [31:0]      o_r_y,
    output logic [31:0]      o_r_z,
    output logic [31:0]      o_scalar_out,
    output logic             o_is_less,
    output logic             o_is_greater,
    output logic             o_is_equal,
    output logic             o_divide_by_zero,
    output logic             o_saturated
);

    localparam int ISQ = v3alu_pkg::ISQ_STAGES;
    localparam int NW  = 32 + FRAC_BITS;
    localparam int VL  = ISQ + NW;
    localparam int LAT = 3 + VL;

    // Sideband carried alongside the square root.
    typedef struct packed {
        logic [3:0]        op;
        v3alu_pkg::t_vec   a;
        logic [31:0]       s;
        v3alu_pkg::t_early early;
    } t_pre;

    // Sideband carried alongside the dividers.
    typedef struct packed {
        logic [3:0]        op;
        logic [2:0]        neg;
        v3alu_pkg::t_early early;
    } t_post;

    v3alu_pkg::t_vec        w_a, w_b;
    v3alu_pkg::t_lane [2:0] w_lane;
    v3alu_pkg::t_early      w_early;
    logic [63:0]            w_sumsq;
    logic [31:0]            w_root;

    logic                   r_vld_s1, r_vld_s2;
    logic [VL-1:0]          r_vld_line;
    logic [3:0]             r_op_s1, r_op_s2;
    v3alu_pkg::t_vec        r_a_s1, r_b_s1, r_a_s2;
    logic [31:0]            r_s_s1, r_s_s2;
    t_pre                   r_pre  [ISQ];
    t_post                  r_post [NW];

    t_pre                   w_pre;
    t_post                  n_post;
    logic [NW-1:0]          w_num [3];
    logic [NW-1:0]          w_quo [3];
    logic [31:0]            w_den;
    logic [31:0]            w_den_out [3];

    v3alu_pkg::t_early      n_res, r_res;
    logic                   n_dz, r_dz, r_valid;

    assign busy = 1'b0;
    assign w_a  = {i_a_z, i_a_y, i_a_x};
    assign w_b  = {i_b_z, i_b_y, i_b_x};

    // Stage 1: one lane per component.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk   (i_clk),
            .i_op    (i_opcode),
            .i_a_i   (w_a[g]),
            .i_b_i   (w_b[g]),
            .i_a_j   (w_a[(g + 1) % 3]),
            .i_b_j   (w_b[(g + 1) % 3]),
            .i_a_k   (w_a[(g + 2) % 3]),
            .i_b_k   (w_b[(g + 2) % 3]),
            .i_s     (i_scalar_in),
            .i_op_s1 (r_op_s1),
            .o_lane  (w_lane[g])
        );
    end

    // Stage 2: results that need neither root nor division are final here.
    v3alu_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .i_clk   (i_clk),
        .i_op    (r_op_s1),
        .i_a     (r_a_s1),
        .i_b     (r_b_s1),
        .i_lane  (w_lane),
        .o_early (w_early),
        .o_sumsq (w_sumsq)
    );

    v3alu_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_n    (w_sumsq),
        .o_root (w_root)
    );

    // Divider inputs: the scalar for divide, otherwise the length of A.
    always_comb begin
        w_pre = r_pre[ISQ-1];
        if (w_pre.op == v3alu_pkg::OP_DIV) begin
            w_den = w_pre.s[31] ? (~w_pre.s + 32'd1) : w_pre.s;
        end else begin
            w_den = w_root;
        end
        n_post.op    = w_pre.op;
        n_post.early = w_pre.early;
        for (int i = 0; i < 3; i++) begin
            w_num[i] = {(w_pre.a[i][31] ? (~w_pre.a[i] + 32'd1) : w_pre.a[i]),
                        {FRAC_BITS{1'b0}}};
            n_post.neg[i] = (w_pre.op == v3alu_pkg::OP_DIV) ?
                            (w_pre.a[i][31] ^ w_pre.s[31]) : w_pre.a[i][31];
        end
    end

    v3alu_div #(.NW(NW)) u_div0 (
        .i_clk (i_clk), .i_num (w_num[0]), .i_den (w_den),
        .o_quo (w_quo[0]), .o_den (w_den_out[0])
    );
    v3alu_div #(.NW(NW)) u_div1 (
        .i_clk (i_clk), .i_num (w_num[1]), .i_den (w_den),
        .o_quo (w_quo[1]), .o_den (w_den_out[1])
    );
    v3alu_div #(.NW(NW)) u_div2 (
        .i_clk (i_clk), .i_num (w_num[2]), .i_den (w_den),
        .o_quo (w_quo[2]), .o_den (w_den_out[2])
    );

    // Final selection: the carried divisor is the length for the length opcode and
    // tells a zero divisor apart for divide and normalize.
    always_comb begin
        t_post       post;
        logic        hi, ovf;
        logic [31:0] val;
        post  = r_post[NW-1];
        hi    = 1'b0;
        ovf   = 1'b0;
        val   = '0;
        n_res = post.early;
        n_dz  = 1'b0;
        unique case (post.op)
            v3alu_pkg::OP_DIV, v3alu_pkg::OP_NORM: begin
                if (w_den_out[0] == 32'd0) begin
                    n_dz = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        hi = |w_quo[i][NW-1:32];
                        if (post.neg[i]) begin
                            ovf = hi | (w_quo[i][31] & (|w_quo[i][30:0]));
                            val = ovf ? 32'h8000_0000 : (~w_quo[i][31:0] + 32'd1);
                        end else begin
                            ovf = hi | w_quo[i][31];
                            val = ovf ? 32'h7FFF_FFFF : w_quo[i][31:0];
                        end
                        n_res.vec[i] = val;
                        n_res.sat    = n_res.sat | ovf;
                    end
                end
            end
            v3alu_pkg::OP_LEN: begin
                if (w_den_out[0][31]) begin
                    n_res.sc  = 32'h7FFF_FFFF;
                    n_res.sat = 1'b1;
                end else begin
                    n_res.sc = w_den_out[0];
                end
            end
            default: ;
        endcase
    end

    // Payload pipeline registers.
    always_ff @(posedge i_clk) begin
        r_op_s1 <= i_opcode;
        r_a_s1  <= w_a;
        r_b_s1  <= w_b;
        r_s_s1  <= i_scalar_in;
        r_op_s2 <= r_op_s1;
        r_a_s2  <= r_a_s1;
        r_s_s2  <= r_s_s1;
        r_pre[0] <= '{op: r_op_s2, a: r_a_s2, s: r_s_s2, early: w_early};
        for (int k = 1; k < ISQ; k++) begin
            r_pre[k] <= r_pre[k-1];
        end
        r_post[0] <= n_post;
        for (int k = 1; k < NW; k++) begin
            r_post[k] <= r_post[k-1];
        end
        r_res <= n_res;
        r_dz  <= n_dz;
    end

    // Valid bits follow the items through the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s1   <= 1'b0;
            r_vld_s2   <= 1'b0;
            r_vld_line <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_vld_s1   <= start && !busy;
            r_vld_s2   <= r_vld_s1;
            r_vld_line <= {r_vld_line[VL-2:0], r_vld_s2};
            r_valid    <= r_vld_line[VL-1];
        end
    end

    assign o_valid          = r_valid;
    assign o_r_x            = r_res.vec[0];
    assign o_r_y            = r_res.vec[1];
    assign o_r_z            = r_res.vec[2];
    assign o_scalar_out     = r_res.sc;
    assign o_is_less        = r_res.lt;
    assign o_is_greater     = r_res.gt;
    assign o_is_equal       = r_res.eq;
    assign o_divide_by_zero = r_dz;
    assign o_saturated      = r_res.sat;

    `V3ALU_ASSERT(a_latency, i_clk, i_rst_n, (start && !busy) |-> ##LAT o_valid)
    `V3ALU_ASSERT(a_origin, i_clk, i_rst_n, o_valid |-> $past(start, LAT))
    `V3ALU_NEVER(a_ltgt, i_clk, i_rst_n, o_valid && o_is_less && o_is_greater)
    `V3ALU_ASSERT(a_dzzero, i_clk, i_rst_n,
        (o_valid && o_divide_by_zero) |->
        (o_r_x == 32'd0 && o_r_y == 32'd0 && o_r_z == 32'd0 && !o_saturated))
    `V3ALU_ASSERT(a_den_match, i_clk, i_rst_n,
        (w_den_out[1] === w_den_out[0]) && (w_den_out[2] === w_den_out[0]))

endmodule
`default_nettype wire

// ===== tb/vec3_alu_checker.sv =====
// Result predictor and scoreboard for the three-component vector ALU.
`timescale 1ns / 100ps
`default_nettype none
module vec3_alu_checker #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [31:0] i_a_x,
    input  wire logic [31:0] i_a_y,
    input  wire logic [31:0] i_a_z,
    input  wire logic [31:0] i_b_x,
    input  wire logic [31:0] i_b_y,
    input  wire logic [31:0] i_b_z,
    input  wire logic [31:0] i_scalar_in,
    input  wire logic        o_valid,
    input  wire logic [31:0] o_r_x,
    input  wire logic [31:0] o_r_y,
    input  wire logic [31:0] o_r_z,
    input  wire logic [31:0] o_scalar_out,
    input  wire logic        o_is_less,
    input  wire logic        o_is_greater,
    input  wire logic        o_is_equal,
    input  wire logic        o_divide_by_zero,
    input  wire logic        o_saturated,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [31:0] sc;
        logic        lt;
        logic        gt;
        logic        eq;
        logic        dz;
        logic        sat;
    } t_alu_result;

    t_alu_result expected_results[$];

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                   inout logic flag);
        if (v > 128'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            flag = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Integer square root, floor, of a nonnegative value.
    function automatic logic [127:0] root_floor(input logic [127:0] n);
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        lo = 0;
        hi = 128'd1 << 64;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= n) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic t_alu_result compute_result(input logic [3:0] op,
            input logic [2:0][31:0] av, input logic [2:0][31:0] bv, input logic [31:0] sv);
        t_alu_result res;
        logic signed [127:0] a [3];
        logic signed [127:0] b [3];
        logic signed [127:0] s;
        logic signed [127:0] w [3];
        logic signed [127:0] acc;
        logic [127:0] sqa;
        logic [127:0] sqb;
        logic [127:0] len;
        logic flag;
        res = '0;
        flag = 1'b0;
        for (int k = 0; k < 3; k++) begin
            a[k] = 128'(signed'(av[k]));
            b[k] = 128'(signed'(bv[k]));
            w[k] = 0;
        end
        s = 128'(signed'(sv));
        sqa = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        sqb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
        len = root_floor(sqa);
        case (op)
            v3alu_pkg::OP_ADD:
                for (int k = 0; k < 3; k++) w[k] = clamp32(a[k] + b[k], flag);
            v3alu_pkg::OP_SUB:
                for (int k = 0; k < 3; k++) w[k] = clamp32(a[k] - b[k], flag);
            v3alu_pkg::OP_NEG:
                for (int k = 0; k < 3; k++) w[k] = clamp32(-a[k], flag);
            v3alu_pkg::OP_SCALE: for (int k = 0; k < 3; k++)
                w[k] = clamp32((a[k] * s) >>> FRAC_BITS, flag);
            v3alu_pkg::OP_MUL: for (int k = 0; k < 3; k++)
                w[k] = clamp32((a[k] * b[k]) >>> FRAC_BITS, flag);
            v3alu_pkg::OP_DIV: begin
                if (s == 0) res.dz = 1'b1;
                else for (int k = 0; k < 3; k++)
                    w[k] = clamp32((a[k] <<< FRAC_BITS) / s, flag);
            end
            v3alu_pkg::OP_DOT: begin
                acc = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
                res.sc = clamp32(acc >>> FRAC_BITS, flag);
            end
            v3alu_pkg::OP_CROSS: begin
                w[0] = clamp32((a[1]*b[2] - a[2]*b[1]) >>> FRAC_BITS, flag);
                w[1] = clamp32((a[2]*b[0] - a[0]*b[2]) >>> FRAC_BITS, flag);
                w[2] = clamp32((a[0]*b[1] - a[1]*b[0]) >>> FRAC_BITS, flag);
            end
            v3alu_pkg::OP_LEN: res.sc = clamp32($signed(len), flag);
            v3alu_pkg::OP_NORM: begin
                if (len == 0) res.dz = 1'b1;
                else for (int k = 0; k < 3; k++)
                    w[k] = clamp32((a[k] <<< FRAC_BITS) / $signed(len), flag);
            end
            v3alu_pkg::OP_CMP: begin
                res.lt = sqa < sqb;
                res.gt = sqa > sqb;
            end
            v3alu_pkg::OP_EQ: res.eq = (av == bv);
            default: ;
        endcase
        res.rx = w[0][31:0];
        res.ry = w[1][31:0];
        res.rz = w[2][31:0];
        res.sat = flag;
        return res;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_alu_result got;
        t_alu_result want;
        if (i_rst_n && start && !busy)
            expected_results.push_back(compute_result(i_opcode, {i_a_z, i_a_y, i_a_x},
                {i_b_z, i_b_y, i_b_x}, i_scalar_in));
        if (i_rst_n && o_valid) begin
            got = '{o_r_x, o_r_y, o_r_z, o_scalar_out, o_is_less, o_is_greater,
                    o_is_equal, o_divide_by_zero, o_saturated};
            o_checked <= o_checked + 1;
            if (expected_results.size() == 0) begin
                o_fail_count <= o_fail_count + 1;
                if (o_fail_count < 10) $display("unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display({"mismatch: exp r=%h %h %h sc=%h flags=%b, ",
                                  "got r=%h %h %h sc=%h flags=%b"},
                            want.rx, want.ry, want.rz, want.sc,
                            {want.lt, want.gt, want.eq, want.dz, want.sat},
                            got.rx, got.ry, got.rz, got.sc,
                            {got.lt, got.gt, got.eq, got.dz, got.sat});
                end
            end
        end
    end

    initial begin
        o_fail_count = 0;
        o_checked = 0;
    end
endmodule
`default_nettype wire

// ===== tb/tb_vec3_fixed_point_alu_top.sv =====
// Stimulus and verdict for the fixed-point vector ALU testbench.
`timescale 1ns / 100ps
`default_nettype none
module tb_vec3_fixed_point_alu_top;

    localparam int FRAC_BITS = 16;
    // Pipeline delay of the block, also used to wait out the last results.
    localparam int LATENCY = 67 + FRAC_BITS;
    localparam int N_RANDOM = 1250;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  i_opcode = '0;
    logic [31:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic [31:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic [31:0] i_scalar_in = '0;
    logic        o_valid;
    logic [31:0] o_r_x, o_r_y, o_r_z, o_scalar_out;
    logic        o_is_less, o_is_greater, o_is_equal, o_divide_by_zero, o_saturated;
    int          fail_count;
    int          pending;
    int          checked;
    int          issued = 0;

    always #5 i_clk = ~i_clk;

    vec3_fixed_point_alu_top #(.FRAC_BITS(FRAC_BITS)) i_dut (.*);

    vec3_alu_checker #(.FRAC_BITS(FRAC_BITS)) i_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_checked(checked)
    );

    // Random component: mostly moderate values so products stay in range, with
    // occasional full-width and extreme values to drive saturation.
    function automatic logic [31:0] pick_component();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3, 4:    return $urandom();
            5:       return 32'($signed($urandom_range(0, 64)) - 32) <<< FRAC_BITS;
            default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    // Present one item and hold it until the block takes it. Start stays high
    // across back-to-back items; it is lowered for idle gaps, the mid-run drain and the end.
    task automatic send_item(input logic [3:0] op, input logic [31:0] ax, ay, az,
                             input logic [31:0] bx, by, bz, sc);
        i_opcode    <= op;
        i_a_x       <= ax;
        i_a_y       <= ay;
        i_a_z       <= az;
        i_b_x       <= bx;
        i_b_y       <= by;
        i_b_z       <= bz;
        i_scalar_in <= sc;
        start       <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        issued++;
    endtask

    task automatic idle_gap();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: n = 0;
            5, 6, 7, 8:    n = $urandom_range(1, 3);
            default:       n = $urandom_range(10, 120);
        endcase
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic random_item();
        logic [31:0] ax, ay, az;
        logic [3:0] op;
        ax = pick_component();
        ay = pick_component();
        az = pick_component();
        op = 4'($urandom_range(0, 16) == 0 ? $urandom_range(12, 15) : $urandom_range(0, 11));
        // Equality and compare need matching operands now and then to be interesting.
        if ((op == v3alu_pkg::OP_EQ || op == v3alu_pkg::OP_CMP) && $urandom_range(0, 1))
            send_item(op, ax, ay, az, ax, ay, ($urandom_range(0, 2) == 0) ? ~az : az,
                      pick_component());
        else
            send_item(op, ax, ay, az, pick_component(), pick_component(), pick_component(),
                      ($urandom_range(0, 7) == 0) ? 32'd0 : pick_component());
    endtask

    initial begin
        localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
        localparam logic [31:0] MINV = 32'h8000_0000;
        localparam logic [31:0] ONE = 32'h0001_0000;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items: every opcode, field extremes, a zero divisor, a zero
        // vector to normalize, equal operands and two of the unused opcodes.
        send_item(v3alu_pkg::OP_ADD, MAXV, MINV, ONE, MAXV, MINV, ONE, '0);
        send_item(v3alu_pkg::OP_SUB, MINV, MAXV, '0, MAXV, MINV, ONE, '0);
        send_item(v3alu_pkg::OP_NEG, MINV, MAXV, 32'hFFFF_FFFF, '0, '0, '0, '0);
        send_item(v3alu_pkg::OP_SCALE, MAXV, MINV, ONE, '0, '0, '0, MAXV);
        send_item(v3alu_pkg::OP_SCALE, 32'h0003_8000, 32'hFFFF_0001, ONE, '0, '0, '0,
                  32'hFFFE_8000);
        send_item(v3alu_pkg::OP_DIV, ONE, MINV, MAXV, '0, '0, '0, '0);
        send_item(v3alu_pkg::OP_DIV, MAXV, MINV, 32'h0005_0000, '0, '0, '0, 32'h0000_0001);
        send_item(v3alu_pkg::OP_DIV, 32'h0007_0000, MINV, ONE, '0, '0, '0, 32'hFFFF_FFFF);
        send_item(v3alu_pkg::OP_MUL, MINV, MAXV, 32'hFFFF_8000, MINV, MAXV, 32'h0000_8001,
                  '0);
        send_item(v3alu_pkg::OP_DOT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, '0);
        send_item(v3alu_pkg::OP_DOT, 32'h0000_0001, 32'hFFFF_FFFF, ONE, 32'h0000_0003,
                  32'h0000_0005, ONE, '0);
        send_item(v3alu_pkg::OP_CROSS, MINV, MAXV, ONE, MAXV, MINV, 32'hFFFF_0000, '0);
        send_item(v3alu_pkg::OP_LEN, MINV, MINV, MINV, '0, '0, '0, '0);
        send_item(v3alu_pkg::OP_LEN, 32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, '0);
        send_item(v3alu_pkg::OP_NORM, '0, '0, '0, '0, '0, '0, '0);
        send_item(v3alu_pkg::OP_NORM, 32'h0000_0001, '0, '0, '0, '0, '0, '0);
        send_item(v3alu_pkg::OP_NORM, MINV, MAXV, 32'h1234_5678, '0, '0, '0, '0);
        send_item(v3alu_pkg::OP_CMP, ONE, '0, '0, '0, ONE, '0, '0);
        send_item(v3alu_pkg::OP_CMP, MINV, ONE, '0, MAXV, ONE, '0, '0);
        send_item(v3alu_pkg::OP_CMP, ONE, '0, '0, '0, '0, 32'h0002_0000, '0);
        send_item(v3alu_pkg::OP_EQ, MINV, MAXV, ONE, MINV, MAXV, ONE, '0);
        send_item(v3alu_pkg::OP_EQ, MINV, MAXV, ONE, MINV, MAXV, '0, '0);
        send_item(4'd12, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
        send_item(4'd15, MINV, MINV, MINV, MINV, MINV, MINV, MINV);

        for (int n = 0; n < N_RANDOM; n++) begin
            // Once, mid-run, drain the pipeline completely before going on.
            if (n == N_RANDOM / 2) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            // A stretch of back-to-back items with no gaps at all.
            if (n < 200 || n >= 400) idle_gap();
            random_item();
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d items over all twelve operations, unused opcodes and edge values",
                 issued);
        $display("%0d results compared, %0d failures", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Worst case is well under 1250 of the longest idle gaps plus the latency.
    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/v3alu_pkg.sv
design/v3alu_lane.sv
design/v3alu_merge.sv
design/v3alu_isqrt.sv
design/v3alu_div.sv
design/vec3_fixed_point_alu_top.sv
tb/vec3_alu_checker.sv
tb/tb_vec3_fixed_point_alu_top.sv
